// ----- hdl/sfd_pkg.sv -----
// shared types, constants and sizes for the signed fixed decimal to ascii core
// no dependencies; used by every module of the block
package sfd_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int MAX_DECIMALS = 9;
  localparam int DEC_W        = 4;

  // decimal digits needed for the largest magnitude, and enough for leading fraction zeros
  localparam int DIG_BITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int NDIG     = (DIG_BITS > MAX_DECIMALS + 1) ? DIG_BITS : MAX_DECIMALS + 1;
  localparam int POS_W    = $clog2(NDIG);
  localparam int CNT_W    = $clog2(VALUE_BITS);
  localparam int CMP_W    = (POS_W > DEC_W) ? POS_W : DEC_W;

  // queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [DEC_W-1:0] MAX_DEC = DEC_W'(MAX_DECIMALS);

  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_COMMA = 7'd44;
  localparam logic [6:0] CH_MINUS = 7'd45;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] scaled_value;
    logic [DEC_W-1:0]             decimals;
  } in_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [DEC_W-1:0]      dec;
  } job_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic idle;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT,
    ST_COMMA
  } back_state_t;

endpackage

// ----- hdl/signed_fixed_decimal_to_ascii_core.sv -----
// top level of the signed fixed decimal to ascii core: front, job queue, back end
// depends on sfd_pkg, sfd_front, sfd_queue, sfd_back
//
//   channel   handshake             payload          accepted when
//   input     push / full           number (in_t)    push && !full
//   result    empty / pop           symbol (out_t)   pop && !empty
//
// each number is picked up from the queue, converted by serial shift-add-3 over all
// VALUE_BITS magnitude bits, stripped of leading zero digits above the units digit, then sent
// out one character at a time; with 32 bit values skipped zeros and digits always cover all
// ten positions, with a minus sign for a negative number and a comma before fraction digits
// the queue holds two classified numbers so input keeps flowing while one converts
// reset (rst, synchronous) empties the queue and the result register
// a stalled result simply holds the back end in its character states
module signed_fixed_decimal_to_ascii_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  sfd_pkg::in_t  number,
  output logic          empty,
  input  logic          pop,
  output sfd_pkg::out_t symbol
);

  sfd_pkg::job_t         front_job;   // classified item from the front
  sfd_pkg::job_t         back_job;    // oldest queued item
  logic                  q_empty;
  logic                  q_pop;
  logic                  valid;       // result register holds an item
  sfd_pkg::back_status_t status;

  // sign split and digit count clamp
  sfd_front u_front (
    .number (number),
    .job    (front_job)
  );

  // the queue's full flag is the block's full
  sfd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_job),
    .full  (full),
    .pop   (q_pop),
    .rdata (back_job),
    .empty (q_empty)
  );

  // conversion and character sequencing, result register inside
  sfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (back_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .symbol  (symbol),
    .valid   (valid),
    .pop     (pop),
    .status  (status)
  );

  assign empty = !valid;

  // the back end only takes jobs that are there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  // the final character of a number returns the back end to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (status.emit && status.last) |=> status.idle)
    else $error("back end busy after last character");

  // a number never ends on a sign or a comma
  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (!empty && symbol.last) |->
      (symbol.character != sfd_pkg::CH_MINUS && symbol.character != sfd_pkg::CH_COMMA))
    else $error("last mark on a non-digit character");

endmodule

// ----- hdl/sfd_front.sv -----
// front end: splits sign and magnitude, clamps the fraction digit count
// depends on sfd_pkg
module sfd_front (
  input  sfd_pkg::in_t  number,
  output sfd_pkg::job_t job
);

  logic [sfd_pkg::VALUE_BITS-1:0] raw;

  assign raw = number.scaled_value;

  always_comb begin
    job.neg = raw[sfd_pkg::VALUE_BITS-1];
    // negation is exact for the most negative value as an unsigned magnitude
    job.mag = job.neg ? (~raw + sfd_pkg::VALUE_BITS'(1)) : raw;
    job.dec = (number.decimals > sfd_pkg::MAX_DEC) ? sfd_pkg::MAX_DEC : number.decimals;
  end

endmodule

// ----- hdl/sfd_queue.sv -----
// short job queue between the front and the back end
// depends on sfd_pkg
module sfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfd_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output sfd_pkg::job_t rdata,
  output logic          empty
);

  sfd_pkg::job_t             slots [sfd_pkg::QUEUE_DEPTH];
  logic [sfd_pkg::QPTR_W-1:0] wr_ptr;
  logic [sfd_pkg::QPTR_W-1:0] rd_ptr;
  logic [sfd_pkg::QPTR_W:0]   count;
  logic                       do_push;
  logic                       do_pop;

  assign full    = (count == (sfd_pkg::QPTR_W+1)'(sfd_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (sfd_pkg::QPTR_W+1)'(do_push) - (sfd_pkg::QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

endmodule

// ----- hdl/sfd_back.sv -----
// back end: serial binary to bcd conversion, then character sequencing into an output register
// depends on sfd_pkg
module sfd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sfd_pkg::job_t         job,
  input  logic                  q_empty,
  output logic                  q_pop,
  output sfd_pkg::out_t         symbol,
  output logic                  valid,
  input  logic                  pop,
  output sfd_pkg::back_status_t status
);

  sfd_pkg::back_state_t state;
  sfd_pkg::back_state_t state_next;

  logic [sfd_pkg::VALUE_BITS-1:0] shift;
  logic [sfd_pkg::NDIG*4-1:0]     bcd;
  logic [sfd_pkg::NDIG*4-1:0]     bcd_adj;
  logic [sfd_pkg::NDIG*4-1:0]     bcd_next;
  logic [sfd_pkg::CNT_W-1:0]      cnt;
  logic [sfd_pkg::POS_W-1:0]      pos;
  logic                           neg;
  logic [sfd_pkg::DEC_W-1:0]      dec;
  logic [3:0]                     digit_cur;
  logic                           slot_free;
  logic                           skip_zero;
  logic                           emit;
  logic [6:0]                     emit_char;
  logic                           emit_last;

  // add three to every digit of five or more, then shift in the next magnitude bit
  always_comb begin
    for (int i = 0; i < sfd_pkg::NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
    bcd_next = {bcd_adj[sfd_pkg::NDIG*4-2:0], shift[sfd_pkg::VALUE_BITS-1]};
  end

  assign digit_cur = bcd[{pos, 2'b00} +: 4];
  assign slot_free = !valid || pop;
  assign skip_zero = (sfd_pkg::CMP_W'(pos) > sfd_pkg::CMP_W'(dec)) && (digit_cur == 4'd0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sfd_pkg::ST_IDLE:  if (!q_empty) state_next = sfd_pkg::ST_CONV;
      sfd_pkg::ST_CONV:  if (cnt == '0) state_next = sfd_pkg::ST_SKIP;
      sfd_pkg::ST_SKIP: begin
        if (!skip_zero) state_next = neg ? sfd_pkg::ST_SIGN : sfd_pkg::ST_DIGIT;
      end
      sfd_pkg::ST_SIGN:  if (slot_free) state_next = sfd_pkg::ST_DIGIT;
      sfd_pkg::ST_DIGIT: begin
        if (slot_free) begin
          if (pos == '0) begin
            state_next = sfd_pkg::ST_IDLE;
          end else if (sfd_pkg::CMP_W'(pos) == sfd_pkg::CMP_W'(dec)) begin
            state_next = sfd_pkg::ST_COMMA;
          end
        end
      end
      sfd_pkg::ST_COMMA: if (slot_free) state_next = sfd_pkg::ST_DIGIT;
      default:           state_next = sfd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_char = sfd_pkg::CH_ZERO;
    emit_last = 1'b0;
    case (state)
      sfd_pkg::ST_IDLE: q_pop = !q_empty;
      sfd_pkg::ST_SIGN: begin
        emit      = slot_free;
        emit_char = sfd_pkg::CH_MINUS;
      end
      sfd_pkg::ST_DIGIT: begin
        emit      = slot_free;
        emit_char = sfd_pkg::CH_ZERO + {3'b000, digit_cur};
        emit_last = (pos == '0);
      end
      sfd_pkg::ST_COMMA: begin
        emit      = slot_free;
        emit_char = sfd_pkg::CH_COMMA;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) valid <= 1'b1;
      else if (pop) valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      symbol.character <= emit_char;
      symbol.last      <= emit_last;
    end
    case (state)
      sfd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          shift <= job.mag;
          bcd   <= '0;
          neg   <= job.neg;
          dec   <= job.dec;
          cnt   <= sfd_pkg::CNT_W'(sfd_pkg::VALUE_BITS - 1);
        end
      end
      sfd_pkg::ST_CONV: begin
        bcd   <= bcd_next;
        shift <= shift << 1;
        cnt   <= cnt - 1'b1;
        if (cnt == '0) pos <= sfd_pkg::POS_W'(sfd_pkg::NDIG - 1);
      end
      sfd_pkg::ST_SKIP: begin
        if (skip_zero) pos <= pos - 1'b1;
      end
      sfd_pkg::ST_DIGIT: begin
        if (slot_free && pos != '0) pos <= pos - 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign status.emit = emit;
  assign status.last = emit_last;
  assign status.idle = (state == sfd_pkg::ST_IDLE);

endmodule
